// ===== design/sfu_pkg.sv =====
// Shared types, constants and helpers for the saturating fixed-point unit.
// No dependencies; used by every module of the block.
package sfu_pkg;

   localparam int UNITS_DEFAULT = 60;

   // largest magnitude of the symmetric fixed-point range
   localparam logic [30:0] FX_MAX = 31'h3FFF_FFFF;

   // double exponent bias plus the fraction width
   localparam logic signed [12:0] EXP_OFFSET = 13'sd1075;

   typedef enum logic [2:0] {
      ACT_NEAREST = 3'd0,
      ACT_FLOOR   = 3'd1,
      ACT_CEIL    = 3'd2,
      ACT_ADD     = 3'd3,
      ACT_SUB     = 3'd4,
      ACT_NEG     = 3'd5,
      ACT_ABS     = 3'd6,
      ACT_SCALE   = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      RND_NEAREST = 2'd0,
      RND_FLOOR   = 2'd1,
      RND_CEIL    = 2'd2,
      RND_TRUNC   = 2'd3
   } mode_type;

   // class of the double product
   typedef enum logic [1:0] {
      K_ZERO = 2'd0,
      K_SAT  = 2'd1,
      K_TINY = 2'd2,
      K_NORM = 2'd3
   } kind_type;

   // per-item control that rides along the pipeline
   typedef struct packed {
      logic        is_fixed;
      logic [30:0] fixed_res;
      kind_type    kind;
      mode_type    mode;
      logic        sign;
      logic [10:0] exp;
   } tag_type;

   // clamp a 32-bit signed value into the symmetric range
   function automatic logic [30:0] sat_fx(logic signed [31:0] v);
      logic [30:0] r;
      if (v > $signed({1'b0, FX_MAX})) begin
         r = FX_MAX;
      end else if (v < -$signed({1'b0, FX_MAX})) begin
         r = 31'(-FX_MAX);
      end else begin
         r = v[30:0];
      end
      return r;
   endfunction

endpackage

// ===== design/sfu_unpack.sv =====
// Input stage: decodes the action, splits the double, does integer ops.
// Depends on sfu_pkg.
module sfu_unpack #(
   parameter int UNITS_PER_WHOLE = sfu_pkg::UNITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [2:0]         action,
   input  logic signed [30:0] operand_a,
   input  logic signed [30:0] operand_b,
   input  logic [63:0]        float_bits,
   output logic               valid_ff,
   output sfu_pkg::tag_type   tag_ff,
   output logic [52:0]        mant_ff,
   output logic [30:0]        mult_ff,
   output logic [4:0]         lm_ff
);

   sfu_pkg::action_type act;
   sfu_pkg::tag_type    tag_in;
   logic signed [31:0]  a_ext, b_ext;
   logic [30:0]         mag_a;
   logic [30:0]         mult_in;
   logic [4:0]          lm_in;
   logic                fsign, f_nan, f_inf, f_zero, f_sub, m_zero;
   logic [10:0]         fexp;
   logic [51:0]         ffrac;

   // decode and integer actions
   always_comb begin
      act    = sfu_pkg::action_type'(action);
      a_ext  = {operand_a[30], operand_a};
      b_ext  = {operand_b[30], operand_b};
      fsign  = float_bits[63];
      fexp   = float_bits[62:52];
      ffrac  = float_bits[51:0];
      f_nan  = (fexp == 11'h7FF) && (ffrac != 52'd0);
      f_inf  = (fexp == 11'h7FF) && (ffrac == 52'd0);
      f_zero = (fexp == 11'd0) && (ffrac == 52'd0);
      f_sub  = (fexp == 11'd0) && (ffrac != 52'd0);
      mag_a  = operand_a[30] ? 31'(-operand_a) : operand_a;

      tag_in.is_fixed  = 1'b1;
      tag_in.fixed_res = '0;
      tag_in.mode      = sfu_pkg::RND_TRUNC;
      tag_in.sign      = fsign;
      tag_in.exp       = fexp;
      mult_in          = 31'(UNITS_PER_WHOLE);
      case (act)
         sfu_pkg::ACT_NEAREST: begin
            tag_in.is_fixed = 1'b0;
            tag_in.mode     = sfu_pkg::RND_NEAREST;
         end
         sfu_pkg::ACT_FLOOR: begin
            tag_in.is_fixed = 1'b0;
            tag_in.mode     = sfu_pkg::RND_FLOOR;
         end
         sfu_pkg::ACT_CEIL: begin
            tag_in.is_fixed = 1'b0;
            tag_in.mode     = sfu_pkg::RND_CEIL;
         end
         sfu_pkg::ACT_ADD: tag_in.fixed_res = sfu_pkg::sat_fx(a_ext + b_ext);
         sfu_pkg::ACT_SUB: tag_in.fixed_res = sfu_pkg::sat_fx(a_ext - b_ext);
         sfu_pkg::ACT_NEG: tag_in.fixed_res = sfu_pkg::sat_fx(-a_ext);
         sfu_pkg::ACT_ABS: tag_in.fixed_res = sfu_pkg::sat_fx({1'b0, mag_a});
         default: begin
            tag_in.is_fixed = 1'b0;
            tag_in.sign     = fsign ^ operand_a[30];
            mult_in         = mag_a;
         end
      endcase

      // product class
      m_zero = (mult_in == 31'd0);
      if (f_nan || (f_inf && m_zero)) begin
         tag_in.kind = sfu_pkg::K_ZERO;
      end else if (f_inf) begin
         tag_in.kind = sfu_pkg::K_SAT;
      end else if (f_zero || m_zero) begin
         tag_in.kind = sfu_pkg::K_ZERO;
      end else if (f_sub) begin
         tag_in.kind = sfu_pkg::K_TINY;
      end else begin
         tag_in.kind = sfu_pkg::K_NORM;
      end

      // leading one of the integer multiplier
      lm_in = '0;
      for (int i = 0; i < 31; i++) begin
         if (mult_in[i]) lm_in = 5'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff  <= tag_in;
         mant_ff <= {1'b1, ffrac};
         mult_ff <= mult_in;
         lm_ff   <= lm_in;
      end
   end

endmodule

// ===== design/sfu_mult.sv =====
// Two-stage 53 x 31 bit significand multiplier: partial products, then sum.
// Depends on sfu_pkg.
module sfu_mult (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  sfu_pkg::tag_type in_tag,
   input  logic [52:0]      mant,
   input  logic [30:0]      mult,
   input  logic [4:0]       lm,
   output logic             valid_ff,
   output sfu_pkg::tag_type tag_ff,
   output logic [83:0]      prod_ff,
   output logic [4:0]       lm_ff
);

   logic             pp_valid_ff;
   sfu_pkg::tag_type pp_tag_ff;
   logic [4:0]       pp_lm_ff;
   logic [56:0]      pp_hi_ff, pp_hi_in;
   logic [57:0]      pp_lo_ff, pp_lo_in;
   logic [83:0]      prod_in;

   // partial products on the upper and lower significand halves
   always_comb begin
      pp_hi_in = 57'(mant[52:27]) * 57'(mult);
      pp_lo_in = 58'(mant[26:0]) * 58'(mult);
      prod_in  = {pp_hi_ff[56:0], 27'd0} + 84'(pp_lo_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_valid_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else if (adv) begin
         pp_valid_ff <= in_valid;
         valid_ff    <= pp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_hi_ff  <= pp_hi_in;
         pp_lo_ff  <= pp_lo_in;
         pp_tag_ff <= in_tag;
         pp_lm_ff  <= lm;
         prod_ff   <= prod_in;
         tag_ff    <= pp_tag_ff;
         lm_ff     <= pp_lm_ff;
      end
   end

endmodule

// ===== design/sfu_conv.sv =====
// Rounds the product to a double, splits integer and fraction, applies the
// rounding mode, sign and saturation. Holds the output register. Depends on sfu_pkg.
module sfu_conv (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  sfu_pkg::tag_type in_tag,
   input  logic [83:0]      prod,
   input  logic [4:0]       lm,
   output logic             out_valid_ff,
   output logic [30:0]      out_result_ff
);

   // round stage
   logic [4:0]       k;
   logic [6:0]       top_idx;
   logic [52:0]      rsig;
   logic             rbit, sticky_r, up;
   logic [53:0]      rn;
   logic [84:0]      pr_in, pr_ff;
   logic [6:0]       top_in, top_ff;
   logic             rd_valid_ff;
   sfu_pkg::tag_type rd_tag_ff;

   // shift stage
   logic signed [12:0] sh, hi;
   logic [12:0]        dneg;
   logic [6:0]         dsh;
   logic [127:0]       prw, shifted;
   logic [29:0]        ip_in, ip_ff;
   logic               half_in, half_ff, stk_in, stk_ff, sat_in, sat_ff;
   logic               sh_valid_ff;
   sfu_pkg::tag_type   sh_tag_ff;

   // finish stage
   logic        frac_nz, inc;
   logic [30:0] mag, magf, res_in;

   // round the exact product to 53 significant bits, ties to even
   always_comb begin
      top_idx  = 7'(lm) + 7'd53;
      k        = lm + 5'(prod[top_idx]);
      rsig     = 53'(prod >> k);
      rbit     = 1'b0;
      sticky_r = 1'b0;
      if (k != 5'd0) begin
         rbit     = prod[k - 5'd1];
         sticky_r = |(prod & ((84'd1 << (k - 5'd1)) - 84'd1));
      end
      up     = rbit && (sticky_r || rsig[0]);
      rn     = {1'b0, rsig} + 54'(up);
      pr_in  = 85'(rn) << k;
      top_in = 7'd52 + 7'(k) + 7'(rn[53]);
   end

   // place the binary point: integer part, half bit, sticky
   always_comb begin
      sh      = $signed({2'b00, rd_tag_ff.exp}) - sfu_pkg::EXP_OFFSET;
      hi      = sh + $signed({6'd0, top_ff});
      dneg    = 13'(-sh);
      dsh     = (dneg > 13'd100) ? 7'd100 : dneg[6:0];
      prw     = 128'(pr_ff);
      shifted = prw >> dsh;
      ip_in   = '0;
      half_in = 1'b0;
      stk_in  = 1'b0;
      sat_in  = 1'b0;
      case (rd_tag_ff.kind)
         sfu_pkg::K_SAT:  sat_in = 1'b1;
         sfu_pkg::K_TINY: stk_in = 1'b1;
         sfu_pkg::K_NORM: begin
            if (hi >= 13'sd30) begin
               sat_in = 1'b1;
            end else if (sh >= 13'sd0) begin
               ip_in = 30'(pr_ff << sh[4:0]);
            end else begin
               ip_in   = shifted[29:0];
               half_in = prw[dsh - 7'd1];
               stk_in  = |(prw & ((128'd1 << (dsh - 7'd1)) - 128'd1));
            end
         end
         default: ;
      endcase
   end

   // rounding mode, sign and clamp
   always_comb begin
      frac_nz = half_ff || stk_ff;
      case (sh_tag_ff.mode)
         sfu_pkg::RND_NEAREST: inc = half_ff;
         sfu_pkg::RND_FLOOR:   inc = sh_tag_ff.sign && frac_nz;
         sfu_pkg::RND_CEIL:    inc = !sh_tag_ff.sign && frac_nz;
         default:              inc = 1'b0;
      endcase
      mag  = {1'b0, ip_ff} + 31'(inc);
      magf = (sat_ff || (mag > sfu_pkg::FX_MAX)) ? sfu_pkg::FX_MAX : mag;
      if (sh_tag_ff.is_fixed) begin
         res_in = sh_tag_ff.fixed_res;
      end else if (sh_tag_ff.sign) begin
         res_in = 31'(-magf);
      end else begin
         res_in = magf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         sh_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         rd_valid_ff  <= in_valid;
         sh_valid_ff  <= rd_valid_ff;
         out_valid_ff <= sh_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pr_ff         <= pr_in;
         top_ff        <= top_in;
         rd_tag_ff     <= in_tag;
         ip_ff         <= ip_in;
         half_ff       <= half_in;
         stk_ff        <= stk_in;
         sat_ff        <= sat_in;
         sh_tag_ff     <= rd_tag_ff;
         out_result_ff <= res_in;
      end
   end

endmodule

// ===== design/saturating_fixed_unit_alu.sv =====
// Top level of the saturating fixed-point unit (values in 1/UNITS_PER_WHOLE).
// Depends on sfu_pkg, sfu_unpack, sfu_mult and sfu_conv.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    action, operand_a, operand_b, float_bits
//   rsp      out        rsp_valid/stall    result
//
// Six register stages: unpack, two multiplier stages, round, shift, output.
// One transfer per cycle is taken while no result is stalled; the depth is set by the
// 53 x 31 bit significand multiply and the round and alignment shifters.
// Reset clears only the stage valid bits.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
module saturating_fixed_unit_alu #(
   parameter int UNITS_PER_WHOLE = sfu_pkg::UNITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_action,
   input  logic signed [30:0] req_operand_a,
   input  logic signed [30:0] req_operand_b,
   input  logic [63:0]        req_float_bits,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [30:0] rsp_result
);

   logic             adv;
   logic             u_valid, m_valid;
   sfu_pkg::tag_type u_tag, m_tag;
   logic [52:0]      u_mant;
   logic [30:0]      u_mult;
   logic [4:0]       u_lm, m_lm;
   logic [83:0]      m_prod;
   logic [30:0]      result;

   // pipeline advances unless a finished result is held
   assign adv        = !(rsp_valid && rsp_stall);
   assign req_stall  = !adv;
   assign rsp_result = $signed(result);

   sfu_unpack #(.UNITS_PER_WHOLE(UNITS_PER_WHOLE)) u_unpack (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (req_valid),
      .action     (req_action),
      .operand_a  (req_operand_a),
      .operand_b  (req_operand_b),
      .float_bits (req_float_bits),
      .valid_ff   (u_valid),
      .tag_ff     (u_tag),
      .mant_ff    (u_mant),
      .mult_ff    (u_mult),
      .lm_ff      (u_lm)
   );

   sfu_mult u_mult_stage (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (u_valid),
      .in_tag   (u_tag),
      .mant     (u_mant),
      .mult     (u_mult),
      .lm       (u_lm),
      .valid_ff (m_valid),
      .tag_ff   (m_tag),
      .prod_ff  (m_prod),
      .lm_ff    (m_lm)
   );

   sfu_conv u_conv (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (m_valid),
      .in_tag        (m_tag),
      .prod          (m_prod),
      .lm            (m_lm),
      .out_valid_ff  (rsp_valid),
      .out_result_ff (result)
   );

endmodule

// ===== dv/saturating_fixed_unit_alu_test.sv =====
// Self-checking testbench for saturating_fixed_unit_alu: directed and random transfers,
// each result checked against a real-valued predictor. Depends on sfu_pkg and the RTL.
module saturating_fixed_unit_alu_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      sfu_pkg::action_type action;
      logic signed [30:0]  op_a;
      logic signed [30:0]  op_b;
      logic [63:0]         fbits;
   } alu_item_type;

   localparam int QUIET_FIRST = 600;
   localparam int QUIET_LAST  = 900;
   localparam int HOLD_AT     = 1200;
   localparam int HOLD_CYCLES = 200;
   localparam int WATCHDOG    = 5000;
   localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] NEG_INF = 64'hFFF0_0000_0000_0000;
   localparam logic [63:0] QNAN    = 64'h7FF8_0000_0000_0001;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_action = '0;
   logic signed [30:0] req_operand_a = '0;
   logic signed [30:0] req_operand_b = '0;
   logic [63:0] req_float_bits = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [30:0] rsp_result;

   alu_item_type pending_items[$];
   logic [30:0] expected_results[$];
   int n_sent = 0;
   int n_checked = 0;
   int n_errors = 0;
   int quiet_cycles = 0;
   int hold_left = 0;
   bit hold_done = 0;
   bit req_taken = 0;

   saturating_fixed_unit_alu uut (.*);

   always #4 clock = ~clock;

   // round a real to an integer count of sixtieths, saturating at the range ends
   function automatic logic [30:0] fix_of_real(real x, sfu_pkg::mode_type mode);
      integer t;
      real frac;
      if (x > 1073741823.0) return sfu_pkg::FX_MAX;
      if (x < -1073741823.0) return 31'(-sfu_pkg::FX_MAX);
      t = $rtoi(x);
      frac = x - $itor(t);
      case (mode)
         sfu_pkg::RND_NEAREST: begin
            if (frac >= 0.5) t = t + 1;
            else if (frac <= -0.5) t = t - 1;
         end
         sfu_pkg::RND_FLOOR: if (frac < 0.0) t = t - 1;
         sfu_pkg::RND_CEIL:  if (frac > 0.0) t = t + 1;
         default: ;
      endcase
      return 31'(t);
   endfunction

   function automatic logic [30:0] clamp_sum(longint v);
      if (v > 64'sd1073741823) return sfu_pkg::FX_MAX;
      if (v < -64'sd1073741823) return 31'(-sfu_pkg::FX_MAX);
      return 31'(v);
   endfunction

   function automatic bit is_nan(logic [63:0] b);
      return b[62:52] == 11'h7FF && b[51:0] != 0;
   endfunction

   function automatic logic [30:0] predict_result(alu_item_type it);
      longint a, b;
      real f;
      a = it.op_a;
      b = it.op_b;
      f = $bitstoreal(it.fbits);
      case (it.action)
         sfu_pkg::ACT_NEAREST, sfu_pkg::ACT_FLOOR, sfu_pkg::ACT_CEIL:
            return is_nan(it.fbits) ? 31'd0
                 : fix_of_real(f * 60.0, sfu_pkg::mode_type'(it.action[1:0]));
         sfu_pkg::ACT_ADD: return clamp_sum(a + b);
         sfu_pkg::ACT_SUB: return clamp_sum(a - b);
         sfu_pkg::ACT_NEG: return clamp_sum(-a);
         sfu_pkg::ACT_ABS: return clamp_sum(a < 0 ? -a : a);
         default: begin
            // zero times infinity is NaN too
            if (is_nan(it.fbits) || (a == 0 && it.fbits[62:0] == POS_INF[62:0]))
               return 31'd0;
            return fix_of_real($itor(a) * f, sfu_pkg::RND_TRUNC);
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [30:0] got, logic [30:0] want);
      n_errors++;
      $display("ERROR t=%0t %s: got %0d expected %0d", $realtime, what,
               $signed(got), $signed(want));
   endtask

   // doubles biased toward the interesting range, with specials mixed in
   function automatic logic [63:0] pick_float();
      logic [63:0] b;
      case ($urandom_range(9))
         0: b = {$urandom, $urandom};
         1: case ($urandom_range(5))
               0: b = POS_INF;
               1: b = NEG_INF;
               2: b = {1'($urandom_range(1)), 11'h7FF, 20'($urandom) | 20'h1, $urandom};
               3: b = {1'($urandom_range(1)), 63'd0};
               4: b = {1'($urandom_range(1)), 11'd0, 20'($urandom), $urandom};
               default: b = {1'($urandom_range(1)), 11'($urandom_range(1060, 1090)),
                             20'($urandom), $urandom};
            endcase
         2: b = $realtobits($itor($urandom_range(4000)) / 120.0 - 16.6);
         default: b = {1'($urandom_range(1)), 11'($urandom_range(990, 1050)),
                       20'($urandom), $urandom};
      endcase
      return b;
   endfunction

   function automatic logic signed [30:0] pick_operand();
      case ($urandom_range(7))
         0: return 31'sh4000_0000;
         1: return $urandom_range(1) ? 31'sh3FFF_FFFF : -31'sh3FFF_FFFF;
         2: return 31'($signed($urandom_range(200)) - 100);
         3: return $urandom_range(1) ? 31'sh3FFF_FFFF - 31'($urandom_range(50))
                                     : -31'sh3FFF_FFFF + 31'($urandom_range(50));
         default: return 31'($urandom);
      endcase
   endfunction

   function automatic bit idle_roll();
      if (n_sent >= QUIET_FIRST && n_sent < QUIET_LAST) return 0;
      return $urandom_range(99) < 16;
   endfunction

   // sample both channels, predict, check, watchdog
   always @(posedge clock) begin
      alu_item_type it;
      logic [30:0] want;
      req_taken = 0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            it.action = sfu_pkg::action_type'(req_action);
            it.op_a = req_operand_a;
            it.op_b = req_operand_b;
            it.fbits = req_float_bits;
            expected_results.push_back(predict_result(it));
            req_taken = 1;
            n_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_result, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_result !== want) report_mismatch("result", rsp_result, want);
            end
            n_checked++;
         end
         if (req_taken || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG) begin
            $display("watchdog expired, %0d results pending", expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // request driver: a new item only once the current one has transferred
   always @(negedge clock) begin
      alu_item_type it;
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_items.size() != 0 && !idle_roll()) begin
            it = pending_items.pop_front();
            req_valid <= 1'b1;
            req_action <= it.action;
            req_operand_a <= it.op_a;
            req_operand_b <= it.op_b;
            req_float_bits <= it.fbits;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall: random, plus one long hold to back the pipeline up
   always @(negedge clock) begin
      if (!hold_done && n_sent >= HOLD_AT) begin
         hold_done = 1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_roll();
      end
   end

   task automatic add_item(sfu_pkg::action_type act, logic signed [30:0] a,
                           logic signed [30:0] b, logic [63:0] f);
      alu_item_type it;
      it.action = act;
      it.op_a = a;
      it.op_b = b;
      it.fbits = f;
      pending_items.push_back(it);
   endtask

   initial begin
      int k;
      alu_item_type it;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: rounding halves, specials, range ends
      add_item(sfu_pkg::ACT_NEAREST, '0, '0, $realtobits(0.025));
      add_item(sfu_pkg::ACT_NEAREST, '0, '0, $realtobits(-0.025));
      add_item(sfu_pkg::ACT_FLOOR, '0, '0, $realtobits(-0.01));
      add_item(sfu_pkg::ACT_CEIL, '0, '0, $realtobits(0.01));
      add_item(sfu_pkg::ACT_NEAREST, '0, '0, QNAN);
      add_item(sfu_pkg::ACT_FLOOR, '0, '0, POS_INF);
      add_item(sfu_pkg::ACT_CEIL, '0, '0, NEG_INF);
      add_item(sfu_pkg::ACT_NEAREST, '0, '0, 64'h8000_0000_0000_0000);
      add_item(sfu_pkg::ACT_CEIL, '0, '0, 64'h0000_0000_0000_0001);
      add_item(sfu_pkg::ACT_FLOOR, '0, '0, $realtobits(1e300));
      add_item(sfu_pkg::ACT_ADD, 31'sh3FFF_FFFF, 31'sh3FFF_FFFF, '1);
      add_item(sfu_pkg::ACT_ADD, 31'sh4000_0000, 31'sh4000_0000, '0);
      add_item(sfu_pkg::ACT_SUB, 31'sh4000_0000, 31'sh3FFF_FFFF, '0);
      add_item(sfu_pkg::ACT_SUB, 31'sh3FFF_FFFF, 31'sh4000_0000, '1);
      add_item(sfu_pkg::ACT_NEG, 31'sh4000_0000, '1, '0);
      add_item(sfu_pkg::ACT_NEG, -31'sh3FFF_FFFF, '0, '0);
      add_item(sfu_pkg::ACT_ABS, 31'sh4000_0000, '0, '1);
      add_item(sfu_pkg::ACT_ABS, -31'sd5, '0, '0);
      add_item(sfu_pkg::ACT_SCALE, '0, '0, POS_INF);
      add_item(sfu_pkg::ACT_SCALE, 31'sd7, '0, QNAN);
      add_item(sfu_pkg::ACT_SCALE, -31'sd7, '0, POS_INF);
      add_item(sfu_pkg::ACT_SCALE, 31'sd1000, '0, $realtobits(-2.5));
      add_item(sfu_pkg::ACT_SCALE, 31'sh3FFF_FFFF, '0, $realtobits(1.0000001));
      add_item(sfu_pkg::ACT_SCALE, 31'sd3, '0, $realtobits(0.3333));

      for (k = 0; k < 2000; k++) begin
         it.action = sfu_pkg::action_type'($urandom_range(7));
         it.op_a = pick_operand();
         it.op_b = pick_operand();
         it.fbits = pick_float();
         pending_items.push_back(it);
      end

      wait (pending_items.size() == 0 && !req_valid && expected_results.size() == 0);
      repeat (20) @(posedge clock);
      if (n_errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
